[src/pwa_pkg.sv]
// shared types and constants for the pose window average block
package pwa_pkg;

    localparam int WINDOW_MAX_DEF = 8;
    localparam logic [3:0] WIN_LEN_RESET = 4'd3;
    localparam int NORM_STEPS = 16;
    localparam logic signed [15:0] QUAT_ONE = 16'sd16384;

    typedef struct packed {
        logic               clear_store;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic        [6:0]  grip_percent;
    } t_pose_in;

    typedef struct packed {
        logic signed [23:0] avg_x;
        logic signed [23:0] avg_y;
        logic signed [23:0] avg_z;
        logic signed [15:0] avg_qx;
        logic signed [15:0] avg_qy;
        logic signed [15:0] avg_qz;
        logic signed [15:0] avg_qw;
        logic        [6:0]  avg_grip;
        logic        [3:0]  sample_count;
    } t_pose_out;

    typedef enum logic [2:0] {
        OP_DIV_X = 3'd0,
        OP_DIV_Y = 3'd1,
        OP_DIV_Z = 3'd2,
        OP_DIV_G = 3'd3,
        OP_NRM_X = 3'd4,
        OP_NRM_Y = 3'd5,
        OP_NRM_Z = 3'd6,
        OP_NRM_W = 3'd7
    } t_op;

endpackage

[src/pwa_div.sv]
// bit-serial restoring divider for the rounded means
module pwa_div #(
    parameter int DW = 29,
    parameter int VW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_div;

    logic [VW:0] rem_sh;
    logic [VW:0] rem_sub;
    logic        ge;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DW-1]};
        ge      = rem_sh >= {1'b0, r_div};
        rem_sub = ge ? (rem_sh - {1'b0, r_div}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= rem_sub[VW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

[src/pwa_norm.sv]
// digit-serial search for one normalized quaternion component
module pwa_norm #(
    parameter int QMW = 19,
    parameter int SQW = 40
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [QMW-1:0] i_mag,
    input  logic [SQW-1:0] i_sq,
    output logic           o_done,
    output logic [14:0]    o_mag
);
    import pwa_pkg::*;

    localparam int PW = SQW + 32;
    localparam int CW = $clog2(NORM_STEPS + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_lim;
    logic [PW-1:0] r_p;
    logic [PW-1:0] r_qs;
    logic [PW-1:0] r_ss;
    logic [15:0]   r_m;

    logic [2*QMW-1:0] mag2;
    logic [PW-1:0]    trial;
    logic             ok;
    logic [16:0]      m_inc;

    always_comb begin
        mag2  = i_mag * i_mag;
        trial = r_p + r_qs + r_ss;
        ok    = trial <= r_lim;
        m_inc = {1'b0, r_m} + 17'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NORM_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lim <= PW'({mag2, 30'b0});
            r_ss  <= PW'({i_sq, 30'b0});
            r_qs  <= '0;
            r_p   <= '0;
            r_m   <= '0;
        end else if (r_busy) begin
            r_p  <= ok ? trial : r_p;
            r_qs <= ok ? ((r_qs >> 1) + r_ss) : (r_qs >> 1);
            r_ss <= r_ss >> 2;
            r_m  <= {r_m[14:0], ok};
        end
    end

    assign o_done = r_done;
    assign o_mag  = m_inc[15:1];

endmodule

[src/pose_window_average.sv]
// pose window average top level: sample store, walk sequencer and result register
// The time a sample item takes is set by three things: the single-port sample memory,
// walked one entry per cycle; the bit-serial divider, run once for each of four means;
// and the digit-serial normalizer, run once for each of four components. When the
// quaternion sum is zero the normalizer is skipped. A new input is taken only in the
// idle state, so the next item waits until the last result is loaded, and a result
// still waiting at the output adds its stall before the next input is taken.
// A clear item is taken in the idle state and starts no walk. The store needs no
// clearing pass: only entries written since the last clear are read.
module pose_window_average #(
    parameter int WINDOW_MAX = pwa_pkg::WINDOW_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pwa_pkg::t_pose_in  i_in,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output pwa_pkg::t_pose_out o_out,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_data
);
    import pwa_pkg::*;

    localparam int AW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FW  = $clog2(WINDOW_MAX + 1);
    localparam int LW  = $clog2(WINDOW_MAX);
    localparam int PSW = 24 + LW;
    localparam int GW  = 8 + LW;
    localparam int QSW = 17 + LW;
    localparam int QMW = QSW - 1;
    localparam int SQW = 2 * QMW + 2;
    localparam int DW  = PSW + 2;
    localparam int VW  = FW + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WALK  = 6'b000010,
        S_SQ    = 6'b000100,
        S_START = 6'b001000,
        S_WAIT  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    t_op    r_op;
    logic [3:0]    r_win;
    logic [AW-1:0] r_oldest;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] r_n;
    logic [FW-1:0] r_iss;
    logic [FW-1:0] r_got;
    logic [1:0]    r_j;
    logic          r_first;
    logic          r_rd_vld;
    logic          r_out_vld;

    t_pose_in r_mem [WINDOW_MAX];
    t_pose_in r_rd;

    logic signed [PSW-1:0] r_sx, r_sy, r_sz;
    logic        [GW-1:0]  r_gs;
    logic signed [QSW-1:0] r_qx, r_qy, r_qz, r_qw;
    logic signed [15:0]    r_rx, r_ry, r_rz, r_rw;
    logic        [SQW-1:0] r_sq;
    t_pose_out             r_res;
    t_pose_out             r_out;

    function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [FW-1:0] b);
        int s;
        s = int'(a) + int'(b);
        if (s >= WINDOW_MAX) s = s - WINDOW_MAX;
        return AW'(s);
    endfunction

    logic [FW-1:0] win_eff;
    logic          keep;
    logic [AW-1:0] oldest_nx;
    logic [FW-1:0] fill_m;
    logic [AW-1:0] slot;
    logic          in_acc;
    logic          out_acc;
    logic          out_load;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    always_comb begin
        if (r_win == 4'd0) begin
            win_eff = FW'(1);
        end else if (32'(r_win) > WINDOW_MAX) begin
            win_eff = FW'(WINDOW_MAX);
        end else begin
            win_eff = FW'(r_win);
        end
        keep      = r_fill >= win_eff;
        oldest_nx = keep ? wrap_add(r_oldest, FW'(1)) : r_oldest;
        fill_m    = keep ? (r_fill - 1'b1) : r_fill;
        slot      = wrap_add(oldest_nx, fill_m);
        in_acc    = i_in_valid && (r_state == S_IDLE);
        out_acc   = r_out_vld && i_out_ready;
        out_load  = (r_state == S_OUT) && (!r_out_vld || i_out_ready);
        rd_en     = (r_state == S_WALK) && (r_iss < r_n);
        rd_addr   = wrap_add(r_oldest, r_iss);
    end

    // sample memory
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_in.clear_store) begin
            r_mem[slot] <= i_in;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // hemisphere alignment against the oldest sample
    logic signed [33:0]    dot;
    logic                  flip;
    logic signed [QSW-1:0] ex, ey, ez, ew;

    always_comb begin
        dot = 34'(r_rx * r_rd.quat_x) + 34'(r_ry * r_rd.quat_y)
            + 34'(r_rz * r_rd.quat_z) + 34'(r_rw * r_rd.quat_w);
        flip = !r_first && dot[33];
        ex = flip ? -QSW'(r_rd.quat_x) : QSW'(r_rd.quat_x);
        ey = flip ? -QSW'(r_rd.quat_y) : QSW'(r_rd.quat_y);
        ez = flip ? -QSW'(r_rd.quat_z) : QSW'(r_rd.quat_z);
        ew = flip ? -QSW'(r_rd.quat_w) : QSW'(r_rd.quat_w);
    end

    // operand selection for the shared units
    logic signed [QSW-1:0]   qsel;
    logic signed [2*QSW-1:0] qsq;
    logic signed [PSW-1:0]   psel;
    logic        [PSW-1:0]   pmag;
    logic        [QMW-1:0]   qmag;
    logic        [DW-1:0]    dividend;
    logic                    is_div;
    logic                    div_start, div_done;
    logic                    norm_start, norm_done;
    logic        [DW-1:0]    div_quot;
    logic        [14:0]      norm_mag;
    logic        [23:0]      pos_q;
    logic signed [QSW-1:0]   qj;

    always_comb begin
        unique case (r_j)
            2'd0:    qj = r_qx;
            2'd1:    qj = r_qy;
            2'd2:    qj = r_qz;
            default: qj = r_qw;
        endcase
        qsq = qj * qj;

        unique case (r_op)
            OP_NRM_X: qsel = r_qx;
            OP_NRM_Y: qsel = r_qy;
            OP_NRM_Z: qsel = r_qz;
            default:  qsel = r_qw;
        endcase
        qmag = qsel[QSW-1] ? QMW'(-qsel) : QMW'(qsel);

        unique case (r_op)
            OP_DIV_X: psel = r_sx;
            OP_DIV_Y: psel = r_sy;
            default:  psel = r_sz;
        endcase
        pmag = psel[PSW-1] ? PSW'(-psel) : PSW'(psel);

        is_div = (r_op == OP_DIV_X) || (r_op == OP_DIV_Y) || (r_op == OP_DIV_Z)
              || (r_op == OP_DIV_G);
        if (r_op == OP_DIV_G) begin
            dividend = DW'({r_gs, 1'b0}) + DW'(r_n);
        end else begin
            dividend = DW'({pmag, 1'b0}) + DW'(r_n);
        end
        div_start  = (r_state == S_START) && is_div;
        norm_start = (r_state == S_START) && !is_div && (r_sq != '0);
        pos_q      = psel[PSW-1] ? -div_quot[23:0] : div_quot[23:0];
    end

    pwa_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  ({r_n, 1'b0}),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    pwa_norm #(
        .QMW (QMW),
        .SQW (SQW)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_mag   (qmag),
        .i_sq    (r_sq),
        .o_done  (norm_done),
        .o_mag   (norm_mag)
    );

    logic signed [15:0] qval;
    always_comb begin
        qval = qsel[QSW-1] ? -16'(norm_mag) : 16'(norm_mag);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= OP_DIV_X;
            r_win     <= WIN_LEN_RESET;
            r_oldest  <= '0;
            r_fill    <= '0;
            r_iss     <= '0;
            r_got     <= '0;
            r_j       <= '0;
            r_first   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_win <= i_cfg_data;
            end
            r_rd_vld <= rd_en;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (out_acc) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.clear_store) begin
                            r_oldest <= '0;
                            r_fill   <= '0;
                        end else begin
                            r_oldest <= oldest_nx;
                            r_fill   <= fill_m + 1'b1;
                            r_iss    <= '0;
                            r_got    <= '0;
                            r_first  <= 1'b1;
                            r_state  <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (rd_en) begin
                        r_iss <= r_iss + 1'b1;
                    end
                    if (r_rd_vld) begin
                        r_first <= 1'b0;
                        r_got   <= r_got + 1'b1;
                        if (r_got == r_n - 1'b1) begin
                            r_j     <= '0;
                            r_state <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    r_j <= r_j + 1'b1;
                    if (r_j == 2'd3) begin
                        r_op    <= OP_DIV_X;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    if (!is_div && (r_sq == '0)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (div_done || norm_done) begin
                        if (r_op == OP_NRM_W) begin
                            r_state <= S_OUT;
                        end else begin
                            r_op    <= t_op'(r_op + 3'd1);
                            r_state <= S_START;
                        end
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // accumulators and result fields
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_in.clear_store) begin
            r_n  <= fill_m + 1'b1;
            r_sx <= '0;
            r_sy <= '0;
            r_sz <= '0;
            r_gs <= '0;
            r_qx <= '0;
            r_qy <= '0;
            r_qz <= '0;
            r_qw <= '0;
            r_sq <= '0;
            r_res.sample_count <= 4'(fill_m + 1'b1);
        end
        if ((r_state == S_WALK) && r_rd_vld) begin
            r_sx <= r_sx + PSW'(r_rd.pos_x);
            r_sy <= r_sy + PSW'(r_rd.pos_y);
            r_sz <= r_sz + PSW'(r_rd.pos_z);
            r_gs <= r_gs + GW'(r_rd.grip_percent);
            r_qx <= r_qx + ex;
            r_qy <= r_qy + ey;
            r_qz <= r_qz + ez;
            r_qw <= r_qw + ew;
            if (r_first) begin
                r_rx <= r_rd.quat_x;
                r_ry <= r_rd.quat_y;
                r_rz <= r_rd.quat_z;
                r_rw <= r_rd.quat_w;
            end
        end
        if (r_state == S_SQ) begin
            r_sq <= r_sq + SQW'($unsigned(qsq));
        end
        if ((r_state == S_START) && !is_div && (r_sq == '0)) begin
            r_res.avg_qx <= '0;
            r_res.avg_qy <= '0;
            r_res.avg_qz <= '0;
            r_res.avg_qw <= QUAT_ONE;
        end
        if ((r_state == S_WAIT) && (div_done || norm_done)) begin
            unique case (r_op)
                OP_DIV_X: r_res.avg_x    <= pos_q;
                OP_DIV_Y: r_res.avg_y    <= pos_q;
                OP_DIV_Z: r_res.avg_z    <= pos_q;
                OP_DIV_G: r_res.avg_grip <= div_quot[6:0];
                OP_NRM_X: r_res.avg_qx   <= qval;
                OP_NRM_Y: r_res.avg_qy   <= qval;
                OP_NRM_Z: r_res.avg_qz   <= qval;
                default:  r_res.avg_qw   <= qval;
            endcase
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(WINDOW_MAX))
        else $error("fill count above store depth");

    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in.clear_store) |=> (r_fill != '0))
        else $error("store empty after a push");

    a_walk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_n == r_fill && r_got <= r_iss))
        else $error("walk count out of step with fill count");
`endif

endmodule

[dv/pose_window_average_tb.sv]
// self-checking testbench for the pose window average block
`timescale 1ns / 1ps

module pose_window_average_tb;
    import pwa_pkg::*;

    localparam int DEPTH = 8;
    localparam int SETTLE_CYCLES = 400;
    localparam int EXP_DEPTH = 64;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    t_pose_in    in_item = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_pose_out   out_item;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;

    // predictor state
    logic [3:0]         win_len;
    logic signed [23:0] st_px [DEPTH];
    logic signed [23:0] st_py [DEPTH];
    logic signed [23:0] st_pz [DEPTH];
    logic signed [15:0] st_qx [DEPTH];
    logic signed [15:0] st_qy [DEPTH];
    logic signed [15:0] st_qz [DEPTH];
    logic signed [15:0] st_qw [DEPTH];
    logic [6:0]         st_grip [DEPTH];
    int                 oldest;
    int                 fill;

    // expected results in order
    t_pose_out exp_fifo [EXP_DEPTH];
    int        exp_wr = 0;
    int        exp_rd = 0;

    pose_window_average DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_item),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .o_out       (out_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [23:0] mean_pos(longint sum, int n);
        longint unsigned mag;
        longint unsigned r;
        mag = (sum < 0) ? -sum : sum;
        r = (2 * mag + n) / (2 * n);
        return (sum < 0) ? 24'(-r) : 24'(r);
    endfunction

    function automatic logic [15:0] norm_comp(longint s, longint unsigned sq);
        logic [127:0]    lhs;
        logic [127:0]    rhs;
        longint unsigned a;
        longint unsigned k;
        int              lo;
        int              hi;
        int              t;
        a = (s < 0) ? -s : s;
        lhs = 128'(a * a) << 30;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            t = (lo + hi + 1) / 2;
            k = 2 * t - 1;
            rhs = 128'(k * k) * 128'(sq);
            if (lhs >= rhs) lo = t;
            else hi = t - 1;
        end
        return (s < 0) ? 16'(-lo) : 16'(lo);
    endfunction

    function automatic void predict_average(t_pose_in p);
        int              w;
        int              slot;
        int              k;
        longint          sx, sy, sz, qx, qy, qz, qw, gs;
        longint          rx, ry, rz, rw, x, y, z, ww;
        longint unsigned sq;
        t_pose_out       r;
        if (p.clear_store) begin
            oldest = 0;
            fill = 0;
            return;
        end
        w = (win_len < 1) ? 1 : (win_len > DEPTH) ? DEPTH : int'(win_len);
        if (fill >= w && fill > 0) begin
            oldest = (oldest + 1) % DEPTH;
            fill--;
        end
        slot = (oldest + fill) % DEPTH;
        st_px[slot] = p.pos_x;
        st_py[slot] = p.pos_y;
        st_pz[slot] = p.pos_z;
        st_qx[slot] = p.quat_x;
        st_qy[slot] = p.quat_y;
        st_qz[slot] = p.quat_z;
        st_qw[slot] = p.quat_w;
        st_grip[slot] = p.grip_percent;
        fill++;
        {sx, sy, sz, qx, qy, qz, qw, gs} = '0;
        {rx, ry, rz, rw} = '0;
        for (int i = 0; i < fill; i++) begin
            k = (oldest + i) % DEPTH;
            x = st_qx[k];
            y = st_qy[k];
            z = st_qz[k];
            ww = st_qw[k];
            if (i == 0) begin
                rx = x; ry = y; rz = z; rw = ww;
            end else if (rx * x + ry * y + rz * z + rw * ww < 0) begin
                x = -x; y = -y; z = -z; ww = -ww;
            end
            sx += st_px[k];
            sy += st_py[k];
            sz += st_pz[k];
            gs += st_grip[k];
            qx += x; qy += y; qz += z; qw += ww;
        end
        r.avg_x = mean_pos(sx, fill);
        r.avg_y = mean_pos(sy, fill);
        r.avg_z = mean_pos(sz, fill);
        sq = qx * qx + qy * qy + qz * qz + qw * qw;
        if (sq == 0) begin
            r.avg_qx = '0;
            r.avg_qy = '0;
            r.avg_qz = '0;
            r.avg_qw = QUAT_ONE;
        end else begin
            r.avg_qx = norm_comp(qx, sq);
            r.avg_qy = norm_comp(qy, sq);
            r.avg_qz = norm_comp(qz, sq);
            r.avg_qw = norm_comp(qw, sq);
        end
        r.avg_grip = 7'((2 * gs + fill) / (2 * fill));
        r.sample_count = 4'(fill);
        exp_fifo[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 n_checked, field, got, want);
        n_errors++;
    endtask

    // result checker
    always @(posedge clk) begin
        t_pose_out want;
        if (rst_n && out_valid && out_ready) begin
            if (exp_wr == exp_rd) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (out_item.avg_x !== want.avg_x)
                    report_mismatch("avg_x", out_item.avg_x, want.avg_x);
                if (out_item.avg_y !== want.avg_y)
                    report_mismatch("avg_y", out_item.avg_y, want.avg_y);
                if (out_item.avg_z !== want.avg_z)
                    report_mismatch("avg_z", out_item.avg_z, want.avg_z);
                if (out_item.avg_qx !== want.avg_qx)
                    report_mismatch("avg_qx", out_item.avg_qx, want.avg_qx);
                if (out_item.avg_qy !== want.avg_qy)
                    report_mismatch("avg_qy", out_item.avg_qy, want.avg_qy);
                if (out_item.avg_qz !== want.avg_qz)
                    report_mismatch("avg_qz", out_item.avg_qz, want.avg_qz);
                if (out_item.avg_qw !== want.avg_qw)
                    report_mismatch("avg_qw", out_item.avg_qw, want.avg_qw);
                if (out_item.avg_grip !== want.avg_grip)
                    report_mismatch("avg_grip", out_item.avg_grip, want.avg_grip);
                if (out_item.sample_count !== want.sample_count)
                    report_mismatch("sample_count", out_item.sample_count,
                                    want.sample_count);
            end
            n_checked++;
        end
    end

    // receiver stalls and long hold-off
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_pose(t_pose_in p);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_item <= p;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        predict_average(p);
        n_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(logic [3:0] len);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_data <= len;
        @(posedge clk);
        cfg_we <= 1'b0;
        win_len = len;
    endtask

    function automatic t_pose_in make_pose(logic signed [15:0] qx, logic signed [15:0] qy,
                                           logic signed [15:0] qz, logic signed [15:0] qw);
        t_pose_in p;
        p.clear_store = 1'b0;
        p.pos_x = 24'($urandom);
        p.pos_y = 24'($urandom);
        p.pos_z = 24'($urandom);
        p.quat_x = qx;
        p.quat_y = qy;
        p.quat_z = qz;
        p.quat_w = qw;
        p.grip_percent = 7'($urandom_range(100));
        return p;
    endfunction

    function automatic logic signed [15:0] rand_quat_comp();
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'($urandom_range(32768)) - 16'sd16384;
    endfunction

    function automatic t_pose_in random_pose();
        t_pose_in p;
        p = make_pose(rand_quat_comp(), rand_quat_comp(), rand_quat_comp(), rand_quat_comp());
        if ($urandom_range(9) == 0) p.grip_percent = 7'($urandom);
        p.clear_store = ($urandom_range(39) == 0);
        return p;
    endfunction

    task automatic test_directed_extremes();
        t_pose_in p;
        write_window(4'd3);
        p = make_pose(16'sd0, 16'sd0, 16'sd0, QUAT_ONE);
        p.pos_x = 24'h7FFFFF; p.pos_y = 24'h7FFFFF; p.pos_z = 24'h7FFFFF;
        p.grip_percent = 7'd100;
        send_pose(p);
        send_pose(p);
        p.pos_x = 24'h800000; p.pos_y = 24'h800000; p.pos_z = 24'h800000;
        p.grip_percent = 7'd0;
        p.quat_w = -16'sd16384;
        send_pose(p);
        // zero quaternion sum falls back to identity
        send_pose(make_pose(16'sd0, 16'sd0, 16'sd0, 16'sd0));
        send_pose(make_pose(16'sd0, 16'sd0, 16'sd0, 16'sd0));
        send_pose(make_pose(16'sd0, 16'sd0, 16'sd0, 16'sd0));
        send_pose(make_pose(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000));
        send_pose(make_pose(-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384));
        p = make_pose(16'sd1, -16'sd1, 16'sd0, 16'sd0);
        p.grip_percent = 7'h7F;
        send_pose(p);
        send_pose(make_pose(16'sd11585, 16'sd0, 16'sd0, -16'sd11585));
    endtask

    task automatic test_clear_and_windows();
        t_pose_in p;
        p = random_pose();
        p.clear_store = 1'b1;
        send_pose(p);
        send_pose(make_pose(16'sd0, 16'sd0, 16'sd16384, 16'sd0));
        // zero window acts as one, large window saturates at the store depth
        write_window(4'd0);
        repeat (3) send_pose(make_pose(rand_quat_comp(), 16'sd0, 16'sd0, 16'sd100));
        write_window(4'd15);
        repeat (10) send_pose(make_pose(rand_quat_comp(), rand_quat_comp(), 16'sd0, 16'sd0));
        // shrink while full keeps the old count
        write_window(4'd2);
        repeat (4) send_pose(make_pose(16'sd0, rand_quat_comp(), 16'sd0, 16'sd9000));
        p.clear_store = 1'b1;
        send_pose(p);
        write_window(4'd8);
        repeat (3) send_pose(make_pose(16'sd0, 16'sd0, 16'sd0, 16'sd16384));
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        write_window(4'($urandom_range(15)));
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 59) write_window(4'($urandom_range(9)));
            send_pose(random_pose());
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        write_window(4'd8);
        hold_cycles = 3000;
        repeat (20) send_pose(random_pose());
        wait_drained();
        repeat (10) send_pose(random_pose());
    endtask

    initial begin
        win_len = WIN_LEN_RESET;
        oldest = 0;
        fill = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_clear_and_windows();
        test_random_phase(0, 0, 170);
        test_random_phase(75, 0, 170);
        test_random_phase(0, 75, 170);
        test_random_phase(20, 20, 170);
        test_backpressure();
        wait_drained();
        $display("sent %0d items and checked %0d averages across window lengths 0 to 15,",
                 n_sent, n_checked);
        $display("clears, identity fallback, idle and stall phases and a long hold-off");
        if (n_errors == 0) begin
            $display("** pose_window_average: PASSED **");
        end else begin
            $display("** pose_window_average: FAILED **");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("timeout");
        $display("** pose_window_average: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
src/pwa_pkg.sv
src/pwa_div.sv
src/pwa_norm.sv
src/pose_window_average.sv
dv/pose_window_average_tb.sv
